/* sv/assert_macros.svh */
// assertion helpers, clocked on i_clk and disabled while i_rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition that must never hold
`define ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed");

`endif

/* sv/cppt_pkg.sv */
`timescale 1ns / 1ps
package cppt_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 12;
    localparam int COORD_W      = 12;
    localparam int VCOUNT_W     = 7;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int KW           = $clog2(MAX_VERTICES + 3);
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int EVAL_W       = PROD_W + 1;

    localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((32'd1 << COORD_BITS) - 32'd1);

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_TEST  = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ADD_STORED    = 2'd0,
        ADD_NONCONVEX = 2'd1,
        ADD_FULL      = 2'd2,
        ADD_NONE      = 2'd3
    } t_add_st;

    typedef enum logic [2:0] {
        PT_OUTSIDE  = 3'd0,
        PT_ON_EDGE  = 3'd1,
        PT_INSIDE   = 3'd2,
        PT_NO_POLY  = 3'd3,
        PT_NOT_TEST = 3'd4
    } t_pt_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_ISSUE,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef enum logic {
        MODE_CONVEX,
        MODE_TEST
    } t_mode;

    typedef struct packed {
        logic               start;
        t_mode              mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               wr_en;
        logic [ADDR_W-1:0]  wr_addr;
        logic               rd_en;
        logic [ADDR_W-1:0]  rd_addr;
        logic               eval;
        logic               first;
    } t_dp_cmd;

    typedef struct packed {
        logic   busy;
        logic   above;
        logic   below;
        t_pt_st pt_res;
    } t_dp_sts;

endpackage

/* sv/cppt_req_if.sv */
`timescale 1ns / 1ps
interface cppt_req_if import cppt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;

    modport source(output valid, req_type, px, py, input ready);
    modport sink(input valid, req_type, px, py, output ready);
endinterface

/* sv/cppt_rsp_if.sv */
`timescale 1ns / 1ps
interface cppt_rsp_if import cppt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          add_status;
    logic                is_convex;
    logic                orientation;
    logic [VCOUNT_W-1:0] vertex_count;
    logic [2:0]          point_status;

    modport source(output valid, add_status, is_convex, orientation, vertex_count,
        point_status, input ready);
    modport sink(input valid, add_status, is_convex, orientation, vertex_count,
        point_status, output ready);
endinterface

/* sv/cppt_cfg_if.sv */
`timescale 1ns / 1ps
interface cppt_cfg_if import cppt_pkg::*; ();
    logic valid;
    logic ready;
    logic enforce_convex;

    modport source(output valid, enforce_convex, input ready);
    modport sink(input valid, enforce_convex, output ready);
endinterface

/* sv/cppt_ram.sv */
`timescale 1ns / 1ps
module cppt_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

/* sv/cppt_dp.sv */
`timescale 1ns / 1ps
module cppt_dp import cppt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts
);
    logic [2*COORD_W-1:0] w_rd_data;
    logic [COORD_W-1:0]   w_rd_x, w_rd_y;
    logic [COORD_W-1:0]   w_xe, w_ye, w_xj, w_yj, w_xi, w_yi;
    logic signed [DIFF_W-1:0] w_dx1, w_dy1, w_dy2, w_dx2;
    logic signed [PROD_W-1:0] n_p1, n_p2;
    logic signed [EVAL_W-1:0] w_ev;
    logic w_neg, w_zero, w_pos;

    logic r_v1, r_eval1, r_first1;
    logic r_v2, r_eval2, r_first2;
    logic [COORD_W-1:0] r_px, r_py, r_w1x, r_w1y, r_w2x, r_w2y;
    logic signed [PROD_W-1:0] r_p1, r_p2;
    logic r_above, r_below, r_done, r_s0neg;
    t_pt_st r_res;

    cppt_ram #(
        .WIDTH(2 * COORD_W),
        .DEPTH(MAX_VERTICES)
    ) u_vram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(i_cmd.wr_addr),
        .i_wr_data({i_cmd.x, i_cmd.y}),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(i_cmd.rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_rd_x = w_rd_data[2*COORD_W-1:COORD_W];
    assign w_rd_y = w_rd_data[COORD_W-1:0];

    // convex: edge from the two previous vertices, probe is the new one
    // test: edge from previous vertex to the new one, probe is the point
    always_comb begin
        if (i_cmd.mode == MODE_CONVEX) begin
            w_xe = r_w2x;  w_ye = r_w2y;
            w_xj = r_w1x;  w_yj = r_w1y;
            w_xi = w_rd_x; w_yi = w_rd_y;
        end else begin
            w_xe = r_w1x;  w_ye = r_w1y;
            w_xj = w_rd_x; w_yj = w_rd_y;
            w_xi = r_px;   w_yi = r_py;
        end
        w_dx1 = $signed({1'b0, w_xj}) - $signed({1'b0, w_xe});
        w_dy1 = $signed({1'b0, w_yi}) - $signed({1'b0, w_ye});
        w_dy2 = $signed({1'b0, w_yj}) - $signed({1'b0, w_ye});
        w_dx2 = $signed({1'b0, w_xi}) - $signed({1'b0, w_xe});
        n_p1  = w_dx1 * w_dy1;
        n_p2  = w_dy2 * w_dx2;
    end

    assign w_ev   = $signed({r_p1[PROD_W-1], r_p1}) - $signed({r_p2[PROD_W-1], r_p2});
    assign w_neg  = w_ev[EVAL_W-1];
    assign w_zero = (w_ev == '0);
    assign w_pos  = !w_neg && !w_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_eval1  <= i_cmd.eval;
        r_first1 <= i_cmd.first;
        r_eval2  <= r_eval1;
        r_first2 <= r_first1;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
        if (r_v1) begin
            r_w2x <= r_w1x;
            r_w2y <= r_w1y;
            r_w1x <= w_rd_x;
            r_w1y <= w_rd_y;
        end
        if (i_cmd.start) begin
            r_px    <= i_cmd.x;
            r_py    <= i_cmd.y;
            r_above <= 1'b0;
            r_below <= 1'b0;
            r_done  <= 1'b0;
            r_res   <= PT_INSIDE;
        end else if (r_v2 && r_eval2) begin
            if (i_cmd.mode == MODE_CONVEX) begin
                r_above <= r_above | w_pos;
                r_below <= r_below | w_neg;
            end else if (!r_done) begin
                if (r_first2) begin
                    r_s0neg <= w_neg;
                    if (w_zero) begin
                        r_res  <= PT_ON_EDGE;
                        r_done <= 1'b1;
                    end
                end else if ((w_neg && !r_s0neg) || (w_pos && r_s0neg)) begin
                    r_res  <= PT_OUTSIDE;
                    r_done <= 1'b1;
                end else if (w_zero) begin
                    r_res  <= PT_ON_EDGE;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy   = r_v1 || r_v2;
    assign o_sts.above  = r_above;
    assign o_sts.below  = r_below;
    assign o_sts.pt_res = r_res;
endmodule

/* sv/cppt_ctrl.sv */
`timescale 1ns / 1ps
module cppt_ctrl import cppt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cppt_req_if.sink          i_req,
    cppt_cfg_if.sink          i_cfg,
    cppt_rsp_if.source        o_rsp,
    output t_dp_cmd           o_cmd,
    input  t_dp_sts           i_sts
);
    t_state r_state, n_state;
    logic   r_enforce;
    logic [CNT_W-1:0] r_count, n_count, r_lim, n_lim;
    logic   r_cvx, n_cvx, r_orient, n_orient;
    logic [COORD_W-1:0] r_x, n_x, r_y, n_y;
    t_add_st r_add_st, n_add_st;
    t_pt_st  r_pt_st, n_pt_st;
    t_mode   r_mode, n_mode;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [KW-1:0] r_k, n_k, r_tot, n_tot;
    logic w_cvx;

    logic r_ov, n_ov;
    t_add_st r_o_add, n_o_add;
    logic r_o_cvx, n_o_cvx, r_o_or, n_o_or;
    logic [VCOUNT_W-1:0] r_o_cnt, n_o_cnt;
    t_pt_st r_o_pt, n_o_pt;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == ST_IDLE);
    assign w_cvx       = !(i_sts.above && i_sts.below);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_enforce <= 1'b0;
            r_count   <= '0;
            r_cvx     <= 1'b1;
            r_orient  <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cvx    <= n_cvx;
            r_orient <= n_orient;
            r_ov     <= n_ov;
            if (i_cfg.valid) begin
                r_enforce <= i_cfg.enforce_convex;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim    <= n_lim;
        r_x      <= n_x;
        r_y      <= n_y;
        r_add_st <= n_add_st;
        r_pt_st  <= n_pt_st;
        r_mode   <= n_mode;
        r_idx    <= n_idx;
        r_k      <= n_k;
        r_tot    <= n_tot;
        r_o_add  <= n_o_add;
        r_o_cvx  <= n_o_cvx;
        r_o_or   <= n_o_or;
        r_o_cnt  <= n_o_cnt;
        r_o_pt   <= n_o_pt;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_lim    = r_lim;
        n_cvx    = r_cvx;
        n_orient = r_orient;
        n_x      = r_x;
        n_y      = r_y;
        n_add_st = r_add_st;
        n_pt_st  = r_pt_st;
        n_mode   = r_mode;
        n_idx    = r_idx;
        n_k      = r_k;
        n_tot    = r_tot;
        n_ov     = r_ov && !o_rsp.ready;
        n_o_add  = r_o_add;
        n_o_cvx  = r_o_cvx;
        n_o_or   = r_o_or;
        n_o_cnt  = r_o_cnt;
        n_o_pt   = r_o_pt;

        o_cmd         = '0;
        o_cmd.mode    = r_mode;
        o_cmd.x       = r_x;
        o_cmd.y       = r_y;
        o_cmd.wr_addr = r_count[ADDR_W-1:0];
        o_cmd.rd_addr = r_idx;

        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_x      = i_req.px & COORD_MASK;
                    n_y      = i_req.py & COORD_MASK;
                    n_add_st = ADD_NONE;
                    n_pt_st  = PT_NOT_TEST;
                    n_state  = ST_FINISH;
                    unique case (t_req'(i_req.req_type))
                        REQ_ADD: begin
                            if (r_count >= CNT_W'(MAX_VERTICES)) begin
                                n_add_st = ADD_FULL;
                            end else begin
                                n_state = ST_WRITE;
                            end
                        end
                        REQ_TEST: begin
                            if (r_count < CNT_W'(2)) begin
                                n_pt_st = PT_NO_POLY;
                            end else begin
                                n_mode  = MODE_TEST;
                                n_idx   = '0;
                                n_k     = '0;
                                n_tot   = KW'(r_count) + KW'(1);
                                n_lim   = r_count;
                                n_state = ST_ISSUE;
                            end
                        end
                        REQ_CLEAR: begin
                            n_count  = '0;
                            n_cvx    = 1'b1;
                            n_orient = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                o_cmd.wr_en = 1'b1;
                if (r_count < CNT_W'(2)) begin
                    // two or fewer vertices are always convex
                    n_count  = r_count + CNT_W'(1);
                    n_cvx    = 1'b1;
                    n_orient = 1'b0;
                    n_add_st = ADD_STORED;
                    n_state  = ST_FINISH;
                end else begin
                    // walk m-2, m-1, 0 .. m-1 over the m = count+1 vertices
                    n_mode  = MODE_CONVEX;
                    n_idx   = ADDR_W'(r_count - CNT_W'(1));
                    n_k     = '0;
                    n_tot   = KW'(r_count) + KW'(3);
                    n_lim   = r_count + CNT_W'(1);
                    n_state = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.start = (r_k == '0);
                o_cmd.eval  = (r_mode == MODE_CONVEX) ? (r_k >= KW'(2)) : (r_k >= KW'(1));
                o_cmd.first = (r_mode == MODE_TEST) && (r_k == KW'(1));
                n_k = r_k + KW'(1);
                if (CNT_W'(r_idx) + CNT_W'(1) == r_lim) begin
                    n_idx = '0;
                end else begin
                    n_idx = r_idx + ADDR_W'(1);
                end
                if (r_k == r_tot - KW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = ST_FINISH;
                    if (r_mode == MODE_TEST) begin
                        n_pt_st = i_sts.pt_res;
                    end else if (r_enforce && !w_cvx) begin
                        n_add_st = ADD_NONCONVEX;
                    end else begin
                        n_count  = r_count + CNT_W'(1);
                        n_cvx    = w_cvx;
                        n_orient = i_sts.below && !i_sts.above;
                        n_add_st = ADD_STORED;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov    = 1'b1;
                    n_o_add = r_add_st;
                    n_o_cvx = r_cvx;
                    n_o_or  = r_orient;
                    n_o_cnt = VCOUNT_W'(r_count);
                    n_o_pt  = r_pt_st;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.add_status   = r_o_add;
    assign o_rsp.is_convex    = r_o_cvx;
    assign o_rsp.orientation  = r_o_or;
    assign o_rsp.vertex_count = r_o_cnt;
    assign o_rsp.point_status = r_o_pt;
endmodule

/* sv/convex_polygon_point_test_top.sv */
// throughput: one word at a time, set by one vertex read per cycle from the vertex ram;
// the next request is taken once the controller is back in idle after the result is loaded
// reset: synchronous active-low i_rst_n empties the polygon, clears enforce_convex
// and drops the result valid; the vertex ram needs no clearing pass
`timescale 1ns / 1ps
`include "assert_macros.svh"
module convex_polygon_point_test_top import cppt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cppt_req_if.sink   i_req,
    cppt_cfg_if.sink   i_cfg,
    cppt_rsp_if.source o_rsp
);
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    cppt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (i_req),
        .i_cfg  (i_cfg),
        .o_rsp  (o_rsp),
        .o_cmd  (w_cmd),
        .i_sts  (w_sts)
    );

    cppt_dp u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_sts  (w_sts)
    );

    `ASSERT_IMP(a_orient_needs_convex, o_rsp.valid && !o_rsp.is_convex, !o_rsp.orientation)
    `ASSERT_IMP(a_one_kind, o_rsp.valid && (o_rsp.point_status != PT_NOT_TEST), o_rsp.add_status == ADD_NONE)
    `ASSERT_NEVER(a_write_while_busy, w_cmd.wr_en && (w_sts.busy || w_cmd.rd_en))
    `ASSERT_NEVER(a_count_range, o_rsp.valid && (o_rsp.vertex_count > VCOUNT_W'(MAX_VERTICES)))
endmodule
